// File: rtl/pvg_pkg.sv
// Shared types, constants and helper functions of the primitive vertex generator.
package pvg_pkg;

  localparam int ANG_W  = 32;
  localparam int QUO_W  = 33;
  localparam int IDX_W  = 11;
  localparam int PART_W = 3;
  localparam int POS_W  = 23;
  localparam int NRM_W  = 16;
  localparam int TEX_W  = 15;
  localparam int HH_W   = 15;
  localparam int SAT_W  = 40;

  // CORDIC start value: 2^30 divided by the rotator gain
  localparam logic [ANG_W-1:0] CORDIC_GAIN = 32'd652032874;

  // Shape codes
  localparam logic [1:0] SHAPE_SPHERE   = 2'd0;
  localparam logic [1:0] SHAPE_CAPSULE  = 2'd1;
  localparam logic [1:0] SHAPE_CYLINDER = 2'd2;

  // Cylinder part codes
  localparam logic [PART_W-1:0] PART_SIDE       = 3'd0;
  localparam logic [PART_W-1:0] PART_TOP_CENTRE = 3'd1;
  localparam logic [PART_W-1:0] PART_TOP_RIM    = 3'd2;
  localparam logic [PART_W-1:0] PART_BOT_CENTRE = 3'd3;
  localparam logic [PART_W-1:0] PART_BOT_RIM    = 3'd4;

  // Register indexes
  localparam logic [1:0] REG_SHAPE_KIND    = 2'd0;
  localparam logic [1:0] REG_SEGMENT_COUNT = 2'd1;
  localparam logic [1:0] REG_RING_COUNT    = 2'd2;
  localparam logic [1:0] REG_HALF_HEIGHT   = 2'd3;

  // Vertex class decided by the front end
  typedef enum logic [2:0] {
    VK_SPHERE,
    VK_CAPSULE,
    VK_SIDE,
    VK_CENTRE,
    VK_RIM
  } vkind_t;

  typedef struct packed {
    logic             bad;
    vkind_t           kind;
    logic             top;
    logic [IDX_W-1:0] ring;
    logic [IDX_W-1:0] col;
  } cmd_t;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] norm_x;
    logic signed [NRM_W-1:0] norm_y;
    logic signed [NRM_W-1:0] norm_z;
    logic [TEX_W-1:0]        tex_u;
    logic [TEX_W-1:0]        tex_v;
    logic                    index_invalid;
  } result_t;

  // arctan(2^-i) as a fraction of a full turn, 2^32 per turn
  function automatic logic [ANG_W-1:0] atan_turn(input int unsigned i);
    logic [ANG_W-1:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Signed saturation to a w-bit range
  function automatic logic signed [SAT_W-1:0] sat_s(input logic signed [SAT_W-1:0] v,
                                                     input int unsigned w);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = signed'((SAT_W'(1) << (w - 1)) - SAT_W'(1));
    lo = -hi - SAT_W'(1);
    if (v > hi) return hi;
    else if (v < lo) return lo;
    return v;
  endfunction

  // Unsigned saturation to a w-bit range
  function automatic logic signed [SAT_W-1:0] sat_u(input logic signed [SAT_W-1:0] v,
                                                     input int unsigned w);
    logic signed [SAT_W-1:0] hi;
    hi = signed'((SAT_W'(1) << w) - SAT_W'(1));
    if (v > hi) return hi;
    else if (v < 0) return '0;
    return v;
  endfunction

endpackage

// File: rtl/pvg_front.sv
// Front end: request check, vertex classification and command queue.
module pvg_front #(
  parameter int MAX_SEGMENTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [pvg_pkg::IDX_W-1:0]     ring_index,
  input  logic [pvg_pkg::IDX_W-1:0]     column_index,
  input  logic [pvg_pkg::PART_W-1:0]    cylinder_part,
  input  logic [1:0]                    shape_kind,
  input  logic [pvg_pkg::IDX_W-1:0]     segment_count,
  input  logic [pvg_pkg::IDX_W-1:0]     ring_count,
  input  logic                          cmd_pop,
  output logic                          cmd_empty,
  output pvg_pkg::cmd_t                 cmd_head
);
  import pvg_pkg::*;

  localparam int FDEPTH = 4;
  localparam int FPTR_W = $clog2(FDEPTH);
  localparam int FCNT_W = $clog2(FDEPTH + 1);

  cmd_t              cmd_in;
  logic              seg_bad;
  logic              ring_bad;
  logic              wr_en;
  cmd_t              fifo_mem [0:FDEPTH-1];
  logic [FPTR_W-1:0] wptr;
  logic [FPTR_W-1:0] rptr;
  logic [FCNT_W-1:0] count;

  // Range checks and vertex class
  always_comb begin
    seg_bad  = (segment_count < 11'd3) || (32'(segment_count) > 32'(MAX_SEGMENTS));
    ring_bad = (ring_count < 11'd2) || (32'(ring_count) > 32'(MAX_SEGMENTS));
    cmd_in.ring = ring_index;
    cmd_in.col  = column_index;
    cmd_in.bad  = 1'b0;
    cmd_in.kind = VK_SPHERE;
    cmd_in.top  = 1'b0;
    priority if (shape_kind > SHAPE_CYLINDER || seg_bad) begin
      cmd_in.bad = 1'b1;
    end else if (shape_kind != SHAPE_CYLINDER) begin
      cmd_in.bad  = ring_bad || (ring_index > ring_count) || (column_index > segment_count);
      cmd_in.kind = (shape_kind == SHAPE_CAPSULE) ? VK_CAPSULE : VK_SPHERE;
      cmd_in.top  = ({ring_index, 1'b0} < {1'b0, ring_count});
    end else begin
      cmd_in.bad = (cylinder_part > PART_BOT_RIM) ||
                   ((cylinder_part == PART_SIDE) && (ring_index > 11'd1)) ||
                   (((cylinder_part == PART_SIDE) || (cylinder_part == PART_TOP_RIM) ||
                     (cylinder_part == PART_BOT_RIM)) && (column_index > segment_count));
      if (cylinder_part == PART_SIDE) begin
        cmd_in.kind = VK_SIDE;
        cmd_in.top  = (ring_index != '0);
      end else begin
        cmd_in.kind = ((cylinder_part == PART_TOP_CENTRE) ||
                       (cylinder_part == PART_BOT_CENTRE)) ? VK_CENTRE : VK_RIM;
        cmd_in.top  = (cylinder_part <= PART_TOP_RIM);
      end
    end
  end

  // Command queue
  assign full      = (count == FCNT_W'(FDEPTH));
  assign cmd_empty = (count == '0);
  assign wr_en     = push && !full;
  assign cmd_head  = fifo_mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_mem[wptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) wptr <= wptr + FPTR_W'(1);
      if (cmd_pop) rptr <= rptr + FPTR_W'(1);
      count <= count + FCNT_W'(wr_en) - FCNT_W'(cmd_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FCNT_W'(FDEPTH))
    else $error("command queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> count != '0)
    else $error("command queue read while empty");
`endif

endmodule

// File: rtl/pvg_div.sv
// Pipelined restoring divider: quotient of num * 2^32 / den, one quotient bit per stage.
module pvg_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pvg_pkg::IDX_W-1:0] num,
  input  logic [pvg_pkg::IDX_W-1:0] den,
  output logic [pvg_pkg::QUO_W-1:0] quo
);
  import pvg_pkg::*;

  logic [IDX_W-1:0] rem_q [0:QUO_W-1];
  logic [QUO_W-1:0] quo_q [0:QUO_W-1];
  logic             ge0;

  // Integer bit: numerator never exceeds the divisor on valid sphere and capsule requests
  assign ge0 = (num >= den);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= ge0 ? (num - den) : num;
      quo_q[0] <= QUO_W'(ge0);
    end
  end

  // Fraction bits
  for (genvar s = 1; s < QUO_W; s++) begin : g_step
    logic [IDX_W:0] trial;
    logic           ge;
    assign trial = {rem_q[s-1], 1'b0};
    assign ge    = (trial >= {1'b0, den});
    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= ge ? IDX_W'(trial - {1'b0, den}) : trial[IDX_W-1:0];
        quo_q[s] <= {quo_q[s-1][QUO_W-2:0], ge};
      end
    end
  end

  assign quo = quo_q[QUO_W-1];

endmodule

// File: rtl/pvg_cordic.sv
// Pipelined CORDIC rotator: sine and cosine of a 32-bit turn fraction.
module pvg_cordic #(
  parameter int STAGES = 16,
  parameter int FRAC   = 14
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [pvg_pkg::ANG_W-1:0] ang,
  output logic signed [FRAC+1:0]    sin_val,
  output logic signed [FRAC+1:0]    cos_val
);
  import pvg_pkg::*;

  localparam int CW = 34;
  localparam int SH = 30 - FRAC;
  localparam logic signed [CW-1:0] QUARTER = 34'sd1073741824;
  localparam logic signed [CW-1:0] HALF    = 34'sd2147483648;
  localparam logic signed [CW-1:0] RND     = CW'((64'd1 << SH) >> 1);
  localparam logic signed [CW-1:0] ONE     = CW'(64'd1 << FRAC);

  logic signed [CW-1:0] x_q [0:STAGES];
  logic signed [CW-1:0] y_q [0:STAGES];
  logic signed [CW-1:0] z_q [0:STAGES];
  logic                 flip_q [0:STAGES];
  logic signed [CW-1:0] z_in;
  logic signed [CW-1:0] z_pre;
  logic                 flip_pre;
  logic signed [CW-1:0] xr;
  logic signed [CW-1:0] yr;
  logic signed [CW-1:0] xc;
  logic signed [CW-1:0] yc;

  // Fold the angle into the right half plane
  always_comb begin
    z_in     = CW'(signed'(ang));
    z_pre    = z_in;
    flip_pre = 1'b0;
    if (z_in > QUARTER) begin
      z_pre    = z_in - HALF;
      flip_pre = 1'b1;
    end else if (z_in < -QUARTER) begin
      z_pre    = z_in + HALF;
      flip_pre = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0]    <= CW'(CORDIC_GAIN);
      y_q[0]    <= '0;
      z_q[0]    <= z_pre;
      flip_q[0] <= flip_pre;
    end
  end

  // Rotation stages
  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [CW-1:0] AT = signed'(CW'(atan_turn(i)));
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - AT;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + AT;
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  // Round to output precision, clamp to +-1, undo the fold
  always_comb begin
    xr = (x_q[STAGES] + RND) >>> SH;
    yr = (y_q[STAGES] + RND) >>> SH;
    xc = (xr > ONE) ? ONE : ((xr < -ONE) ? -ONE : xr);
    yc = (yr > ONE) ? ONE : ((yr < -ONE) ? -ONE : yr);
    if (flip_q[STAGES]) begin
      xc = -xc;
      yc = -yc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= xc[FRAC+1:0];
      sin_val <= yc[FRAC+1:0];
    end
  end

endmodule

// File: rtl/pvg_back.sv
// Back end: angle dividers, CORDIC units, vertex assembly and result buffer.
module pvg_back #(
  parameter int FRAC   = 14,
  parameter int STAGES = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [pvg_pkg::IDX_W-1:0] segment_count,
  input  logic [pvg_pkg::IDX_W-1:0] ring_count,
  input  logic [pvg_pkg::HH_W-1:0]  half_height,
  input  pvg_pkg::cmd_t             cmd_head,
  input  logic                      cmd_empty,
  output logic                      cmd_pop,
  output logic                      empty,
  input  logic                      pop,
  output pvg_pkg::result_t          result
);
  import pvg_pkg::*;

  localparam int CL = STAGES + 2;
  localparam int SW = FRAC + 2;
  localparam int RW = FRAC + 1;
  localparam int PW = 2 * FRAC + 4;
  localparam int VW = FRAC + 9;
  localparam logic signed [PW-1:0] PRND = PW'(64'd1 << (FRAC - 1));

  logic             adv;
  logic [1:0]       obuf_count;
  logic             obuf_wptr;
  logic             obuf_rptr;
  result_t          obuf [0:1];
  logic             obuf_wr;
  logic             obuf_rd;

  logic             d1_valid [0:QUO_W-1];
  cmd_t             d1_cmd   [0:QUO_W-1];
  logic [QUO_W-1:0] qc;
  logic [QUO_W-1:0] qr;
  logic [RW-1:0]    ru_d;
  logic [RW-1:0]    rv_d;

  logic             d2_valid [0:CL-1];
  cmd_t             d2_cmd   [0:CL-1];
  logic [RW-1:0]    d2_ru    [0:CL-1];
  logic [RW-1:0]    d2_rv    [0:CL-1];
  logic signed [SW-1:0] sp;
  logic signed [SW-1:0] cp;
  logic signed [SW-1:0] st;
  logic signed [SW-1:0] ct;

  logic                 m_valid;
  cmd_t                 m_cmd;
  logic [RW-1:0]        m_ru;
  logic [RW-1:0]        m_rv;
  logic signed [SW-1:0] m_cp;
  logic signed [SW-1:0] m_sp;
  logic signed [SW-1:0] m_ct;
  logic signed [PW-1:0] m_pc;
  logic signed [PW-1:0] m_ps;

  logic signed [VW-1:0] px, py, pz, nx, ny, nz, tu, tv;
  logic signed [VW-1:0] one_v, half_v, hsel_v, cp_v, sp_v, ct_v;
  result_t              res_in;

  // Whole pipe moves while the result buffer has room
  assign adv     = (obuf_count != 2'd2);
  assign cmd_pop = adv && !cmd_empty;

  // Sideband along the dividers
  always_ff @(posedge clk) begin
    if (adv) begin
      d1_cmd[0] <= cmd_head;
      for (int k = 1; k < QUO_W; k++) d1_cmd[k] <= d1_cmd[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUO_W; k++) d1_valid[k] <= 1'b0;
    end else if (adv) begin
      d1_valid[0] <= !cmd_empty;
      for (int k = 1; k < QUO_W; k++) d1_valid[k] <= d1_valid[k-1];
    end
  end

  pvg_div u_div_col (
    .clk (clk),
    .en  (adv),
    .num (cmd_head.col),
    .den (segment_count),
    .quo (qc)
  );

  pvg_div u_div_ring (
    .clk (clk),
    .en  (adv),
    .num (cmd_head.ring),
    .den (ring_count),
    .quo (qr)
  );

  // Texture ratios, rounded to nearest from the long quotients
  assign ru_d = RW'(qc >> (ANG_W - FRAC)) + RW'(qc[ANG_W-1-FRAC]);
  assign rv_d = RW'(qr >> (ANG_W - FRAC)) + RW'(qr[ANG_W-1-FRAC]);

  pvg_cordic #(.STAGES(STAGES), .FRAC(FRAC)) u_cordic_phi (
    .clk     (clk),
    .en      (adv),
    .ang     (qc[ANG_W-1:0]),
    .sin_val (sp),
    .cos_val (cp)
  );

  pvg_cordic #(.STAGES(STAGES), .FRAC(FRAC)) u_cordic_theta (
    .clk     (clk),
    .en      (adv),
    .ang     (qr[ANG_W:1]),
    .sin_val (st),
    .cos_val (ct)
  );

  // Sideband along the CORDIC units
  always_ff @(posedge clk) begin
    if (adv) begin
      d2_cmd[0] <= d1_cmd[QUO_W-1];
      d2_ru[0]  <= ru_d;
      d2_rv[0]  <= rv_d;
      for (int k = 1; k < CL; k++) begin
        d2_cmd[k] <= d2_cmd[k-1];
        d2_ru[k]  <= d2_ru[k-1];
        d2_rv[k]  <= d2_rv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < CL; k++) d2_valid[k] <= 1'b0;
    end else if (adv) begin
      d2_valid[0] <= d1_valid[QUO_W-1];
      for (int k = 1; k < CL; k++) d2_valid[k] <= d2_valid[k-1];
    end
  end

  // Product stage
  always_ff @(posedge clk) begin
    if (adv) begin
      m_cmd <= d2_cmd[CL-1];
      m_ru  <= d2_ru[CL-1];
      m_rv  <= d2_rv[CL-1];
      m_cp  <= cp;
      m_sp  <= sp;
      m_ct  <= ct;
      m_pc  <= PW'(st) * PW'(cp);
      m_ps  <= PW'(st) * PW'(sp);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= d2_valid[CL-1];
    end
  end

  // Vertex assembly
  always_comb begin
    one_v  = signed'(VW'(1) << FRAC);
    half_v = signed'(VW'(half_height) << (FRAC - 8));
    hsel_v = m_cmd.top ? half_v : -half_v;
    cp_v   = VW'(m_cp);
    sp_v   = VW'(m_sp);
    ct_v   = VW'(m_ct);
    px = '0; py = '0; pz = '0;
    nx = '0; ny = '0; nz = '0;
    tu = '0; tv = '0;
    if (!m_cmd.bad) begin
      unique case (m_cmd.kind)
        VK_SPHERE, VK_CAPSULE: begin
          nx = VW'((m_pc + PRND) >>> FRAC);
          ny = ct_v;
          nz = VW'((m_ps + PRND) >>> FRAC);
          px = nx;
          pz = nz;
          py = (m_cmd.kind == VK_CAPSULE) ? (ct_v + hsel_v) : ct_v;
          tu = VW'(m_ru);
          tv = VW'(m_rv);
        end
        VK_SIDE: begin
          px = cp_v;
          py = hsel_v;
          pz = sp_v;
          nx = cp_v;
          nz = sp_v;
          tu = VW'(m_ru);
          tv = m_cmd.top ? one_v : '0;
        end
        VK_CENTRE: begin
          py = hsel_v;
          ny = m_cmd.top ? one_v : -one_v;
          tu = one_v >>> 1;
          tv = one_v >>> 1;
        end
        VK_RIM: begin
          px = cp_v;
          py = hsel_v;
          pz = sp_v;
          ny = m_cmd.top ? one_v : -one_v;
          tu = (cp_v + one_v + VW'(1)) >>> 1;
          tv = (sp_v + one_v + VW'(1)) >>> 1;
        end
        default: begin
          px = '0;
        end
      endcase
    end
    res_in.pos_x         = POS_W'(sat_s(SAT_W'(px), POS_W));
    res_in.pos_y         = POS_W'(sat_s(SAT_W'(py), POS_W));
    res_in.pos_z         = POS_W'(sat_s(SAT_W'(pz), POS_W));
    res_in.norm_x        = NRM_W'(sat_s(SAT_W'(nx), NRM_W));
    res_in.norm_y        = NRM_W'(sat_s(SAT_W'(ny), NRM_W));
    res_in.norm_z        = NRM_W'(sat_s(SAT_W'(nz), NRM_W));
    res_in.tex_u         = TEX_W'(sat_u(SAT_W'(tu), TEX_W));
    res_in.tex_v         = TEX_W'(sat_u(SAT_W'(tv), TEX_W));
    res_in.index_invalid = m_cmd.bad;
  end

  // Two-entry result buffer
  assign obuf_wr = adv && m_valid;
  assign obuf_rd = pop && !empty;
  assign empty   = (obuf_count == 2'd0);
  assign result  = obuf[obuf_rptr];

  always_ff @(posedge clk) begin
    if (obuf_wr) begin
      obuf[obuf_wptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      obuf_wptr  <= 1'b0;
      obuf_rptr  <= 1'b0;
      obuf_count <= 2'd0;
    end else begin
      if (obuf_wr) obuf_wptr <= !obuf_wptr;
      if (obuf_rd) obuf_rptr <= !obuf_rptr;
      obuf_count <= obuf_count + 2'(obuf_wr) - 2'(obuf_rd);
    end
  end

`ifndef NO_ASSERTIONS
  a_obuf_bound: assert property (@(posedge clk) disable iff (rst)
    obuf_count <= 2'd2)
    else $error("result buffer count out of range");
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.index_invalid) |->
      (result.pos_x == '0 && result.pos_y == '0 && result.norm_y == '0 &&
       result.tex_u == '0 && result.tex_v == '0))
    else $error("invalid result carries nonzero fields");
  a_obuf_fill: assert property (@(posedge clk) disable iff (rst)
    (obuf_wr && !obuf_rd) |=> obuf_count == $past(obuf_count) + 2'd1)
    else $error("result buffer lost a transfer");
`endif

endmodule

// File: rtl/primitive_vertex_generator_core.sv
// Top level of the primitive vertex generator: register port, front end and back end.
//
//   channel   direction  handshake                  payload
//   request   in         push / full                ring_index, column_index, cylinder_part
//   vertex    out        pop / empty                pos_*, norm_*, tex_u, tex_v, index_invalid
//   config    in         psel, penable, pwrite      paddr, pwdata, prdata (pready tied high)
//
// One vertex per cycle sustained while the result buffer has room; the path runs through
// the 33-stage angle dividers followed by the CORDIC pipelines.
// Synchronous active-high reset clears queues and valid bits; registers take
// their defaults. A full result buffer freezes the back end; the 4-entry
// command queue keeps taking requests until it fills.
module primitive_vertex_generator_core #(
  parameter int MAX_SEGMENTS  = 1024,
  parameter int FRAC_BITS     = 14,
  parameter int CORDIC_STAGES = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [pvg_pkg::IDX_W-1:0]         ring_index,
  input  logic [pvg_pkg::IDX_W-1:0]         column_index,
  input  logic [pvg_pkg::PART_W-1:0]        cylinder_part,
  output logic                              empty,
  input  logic                              pop,
  output logic signed [pvg_pkg::POS_W-1:0]  pos_x,
  output logic signed [pvg_pkg::POS_W-1:0]  pos_y,
  output logic signed [pvg_pkg::POS_W-1:0]  pos_z,
  output logic signed [pvg_pkg::NRM_W-1:0]  norm_x,
  output logic signed [pvg_pkg::NRM_W-1:0]  norm_y,
  output logic signed [pvg_pkg::NRM_W-1:0]  norm_z,
  output logic [pvg_pkg::TEX_W-1:0]         tex_u,
  output logic [pvg_pkg::TEX_W-1:0]         tex_v,
  output logic                              index_invalid,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import pvg_pkg::*;

  logic [1:0]       shape_kind;
  logic [IDX_W-1:0] segment_count;
  logic [IDX_W-1:0] ring_count;
  logic [HH_W-1:0]  half_height;
  logic             cfg_wr;
  logic [1:0]       reg_sel;
  cmd_t             cmd_head;
  logic             cmd_empty;
  logic             cmd_pop;
  result_t          result;

  // Register port
  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind    <= SHAPE_SPHERE;
      segment_count <= 11'd16;
      ring_count    <= 11'd8;
      half_height   <= 15'd256;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_SHAPE_KIND:    shape_kind    <= pwdata[1:0];
        REG_SEGMENT_COUNT: segment_count <= pwdata[IDX_W-1:0];
        REG_RING_COUNT:    ring_count    <= pwdata[IDX_W-1:0];
        REG_HALF_HEIGHT:   half_height   <= pwdata[HH_W-1:0];
        default:           shape_kind    <= shape_kind;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_SHAPE_KIND:    prdata = 32'(shape_kind);
      REG_SEGMENT_COUNT: prdata = 32'(segment_count);
      REG_RING_COUNT:    prdata = 32'(ring_count);
      REG_HALF_HEIGHT:   prdata = 32'(half_height);
      default:           prdata = '0;
    endcase
  end

  pvg_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .ring_index    (ring_index),
    .column_index  (column_index),
    .cylinder_part (cylinder_part),
    .shape_kind    (shape_kind),
    .segment_count (segment_count),
    .ring_count    (ring_count),
    .cmd_pop       (cmd_pop),
    .cmd_empty     (cmd_empty),
    .cmd_head      (cmd_head)
  );

  pvg_back #(.FRAC(FRAC_BITS), .STAGES(CORDIC_STAGES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .segment_count (segment_count),
    .ring_count    (ring_count),
    .half_height   (half_height),
    .cmd_head      (cmd_head),
    .cmd_empty     (cmd_empty),
    .cmd_pop       (cmd_pop),
    .empty         (empty),
    .pop           (pop),
    .result        (result)
  );

  // Result fields
  assign pos_x         = result.pos_x;
  assign pos_y         = result.pos_y;
  assign pos_z         = result.pos_z;
  assign norm_x        = result.norm_x;
  assign norm_y        = result.norm_y;
  assign norm_z        = result.norm_z;
  assign tex_u         = result.tex_u;
  assign tex_v         = result.tex_v;
  assign index_invalid = result.index_invalid;

endmodule

// File: sim/tb_primitive_vertex_generator_core.sv
// Self-checking testbench of the primitive vertex generator core.
`timescale 1ns / 100ps

module tb_primitive_vertex_generator_core;
  import pvg_pkg::*;

  localparam int FRAC       = 14;
  localparam int STAGES     = 16;
  localparam int SEG_MAX    = 1024;
  localparam int DRAIN_WAIT = 80;
  localparam int WDOG_LIMIT = 4000;

  // arctan(2^-i) in turns, 2^32 per turn
  localparam longint ATAN_TURN [STAGES] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  typedef struct {
    logic [IDX_W-1:0]  ring;
    logic [IDX_W-1:0]  col;
    logic [PART_W-1:0] part;
  } vreq_t;

  typedef struct {
    longint px, py, pz, nx, ny, nz, tu, tv;
    bit     bad;
  } vertex_t;

  logic clk;
  logic rst;
  logic push;
  logic full;
  logic [IDX_W-1:0]  ring_index;
  logic [IDX_W-1:0]  column_index;
  logic [PART_W-1:0] cylinder_part;
  logic empty;
  logic pop;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [NRM_W-1:0] norm_x, norm_y, norm_z;
  logic [TEX_W-1:0] tex_u, tex_v;
  logic index_invalid;
  logic psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // register shadow
  logic [1:0]      cfg_shape;
  logic [10:0]     cfg_seg;
  logic [10:0]     cfg_rings;
  logic [HH_W-1:0] cfg_half;

  vreq_t   req_q[$];
  vertex_t vertex_q[$];
  int      fail_cnt;
  int      tx_gap, rx_gap;
  int      rx_hold;
  bit      tx_burst, rx_burst;
  int      idle_cycles;

  primitive_vertex_generator_core i_dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full),
    .ring_index(ring_index), .column_index(column_index), .cylinder_part(cylinder_part),
    .empty(empty), .pop(pop),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .tex_u(tex_u), .tex_v(tex_v), .index_invalid(index_invalid),
    .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  function automatic longint rshift_rnd(longint v, int n);
    return (v + (longint'(1) << (n - 1))) >>> n;
  endfunction

  function automatic longint clampv(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // CORDIC sine/cosine of a turn fraction, Q14 results
  function automatic void turn_sincos(input longint ang, output longint s, output longint c);
    longint one, z, x, y, dx, dy;
    bit flip;
    one = longint'(1) << FRAC;
    z = ang;
    x = longint'(CORDIC_GAIN);
    y = 0;
    flip = 0;
    if (z >= 64'sd2147483648) z -= 64'sd4294967296;
    if (z > 64'sd1073741824) begin
      z -= 64'sd2147483648;
      flip = 1;
    end else if (z < -64'sd1073741824) begin
      z += 64'sd2147483648;
      flip = 1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    x = clampv(rshift_rnd(x, 30 - FRAC), -one, one);
    y = clampv(rshift_rnd(y, 30 - FRAC), -one, one);
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return rshift_rnd(a * b, FRAC);
  endfunction

  function automatic longint tex_ratio(longint n, longint d);
    return ((n << FRAC) + d / 2) / d;
  endfunction

  // Expected vertex for one request under the current register values
  function automatic vertex_t vertex_of(vreq_t r);
    vertex_t e;
    longint one, half, sp, cp, st, ct, ring, col;
    bit bad, top;
    one = longint'(1) << FRAC;
    half = longint'(cfg_half) << (FRAC - 8);
    ring = r.ring;
    col = r.col;
    e = '{default: 0};
    bad = 0;
    if (cfg_shape > SHAPE_CYLINDER || cfg_seg < 3 || cfg_seg > SEG_MAX) bad = 1;
    else if (cfg_shape != SHAPE_CYLINDER) begin
      if (cfg_rings < 2 || cfg_rings > SEG_MAX || ring > cfg_rings || col > cfg_seg) bad = 1;
    end else begin
      if (r.part > PART_BOT_RIM || (r.part == PART_SIDE && ring > 1) ||
          ((r.part == PART_SIDE || r.part == PART_TOP_RIM || r.part == PART_BOT_RIM) &&
           col > cfg_seg)) bad = 1;
    end
    if (!bad) begin
      turn_sincos(((col << 32) / cfg_seg) & 64'hFFFFFFFF, sp, cp);
      if (cfg_shape != SHAPE_CYLINDER) begin
        turn_sincos((ring << 31) / cfg_rings, st, ct);
        e.nx = qmul(st, cp);
        e.ny = ct;
        e.nz = qmul(st, sp);
        e.px = e.nx;
        e.py = e.ny;
        e.pz = e.nz;
        if (cfg_shape == SHAPE_CAPSULE) e.py += (2 * ring < cfg_rings) ? half : -half;
        e.tu = tex_ratio(col, cfg_seg);
        e.tv = tex_ratio(ring, cfg_rings);
      end else if (r.part == PART_SIDE) begin
        e.px = cp;
        e.py = ring != 0 ? half : -half;
        e.pz = sp;
        e.nx = cp;
        e.nz = sp;
        e.tu = tex_ratio(col, cfg_seg);
        e.tv = ring != 0 ? one : 0;
      end else begin
        top = r.part <= PART_TOP_RIM;
        e.py = top ? half : -half;
        e.ny = top ? one : -one;
        if (r.part == PART_TOP_CENTRE || r.part == PART_BOT_CENTRE) begin
          e.tu = one / 2;
          e.tv = one / 2;
        end else begin
          e.px = cp;
          e.pz = sp;
          e.tu = rshift_rnd(cp + one, 1);
          e.tv = rshift_rnd(sp + one, 1);
        end
      end
    end
    e.px = clampv(e.px, -(64'sd1 << 22), (64'sd1 << 22) - 1);
    e.py = clampv(e.py, -(64'sd1 << 22), (64'sd1 << 22) - 1);
    e.pz = clampv(e.pz, -(64'sd1 << 22), (64'sd1 << 22) - 1);
    e.nx = clampv(e.nx, -(64'sd1 << 15), (64'sd1 << 15) - 1);
    e.ny = clampv(e.ny, -(64'sd1 << 15), (64'sd1 << 15) - 1);
    e.nz = clampv(e.nz, -(64'sd1 << 15), (64'sd1 << 15) - 1);
    e.tu = clampv(e.tu, 0, (64'sd1 << 15) - 1);
    e.tv = clampv(e.tv, 0, (64'sd1 << 15) - 1);
    e.bad = bad;
    return e;
  endfunction

  // Request driver: gap drawn per transfer, holds while full
  always @(posedge clk) begin : drv
    int g;
    vreq_t r;
    if (rst) begin
      push <= 1'b0;
      tx_gap <= 0;
    end else begin
      g = tx_gap;
      if (push && !full) begin
        vertex_q.insert(vertex_q.size(),
                        vertex_of('{ring_index, column_index, cylinder_part}));
        g = tx_burst ? 0 : $urandom_range(0, 17);
      end
      if (push && full) begin
        // hold the offered request
      end else if (g > 0) begin
        tx_gap <= g - 1;
        push <= 1'b0;
      end else if (req_q.size() > 0) begin
        r = req_q.pop_front();
        ring_index <= r.ring;
        column_index <= r.col;
        cylinder_part <= r.part;
        push <= 1'b1;
        tx_gap <= 0;
      end else begin
        push <= 1'b0;
        tx_gap <= 0;
      end
    end
  end

  // Vertex monitor: checks each transfer against the oldest expected vertex
  always @(posedge clk) begin : mon
    int g;
    vertex_t e;
    if (rst) begin
      pop <= 1'b0;
      rx_gap <= 0;
    end else begin
      g = rx_gap;
      if (pop && !empty) begin
        if (vertex_q.size() == 0) begin
          $error("unexpected vertex transfer");
          fail_cnt++;
        end else begin
          e = vertex_q.pop_front();
          if (longint'(pos_x) != e.px) begin
            $error("pos_x: expected %0d, got %0d", e.px, pos_x); fail_cnt++;
          end
          if (longint'(pos_y) != e.py) begin
            $error("pos_y: expected %0d, got %0d", e.py, pos_y); fail_cnt++;
          end
          if (longint'(pos_z) != e.pz) begin
            $error("pos_z: expected %0d, got %0d", e.pz, pos_z); fail_cnt++;
          end
          if (longint'(norm_x) != e.nx) begin
            $error("norm_x: expected %0d, got %0d", e.nx, norm_x); fail_cnt++;
          end
          if (longint'(norm_y) != e.ny) begin
            $error("norm_y: expected %0d, got %0d", e.ny, norm_y); fail_cnt++;
          end
          if (longint'(norm_z) != e.nz) begin
            $error("norm_z: expected %0d, got %0d", e.nz, norm_z); fail_cnt++;
          end
          if (longint'(tex_u) != e.tu) begin
            $error("tex_u: expected %0d, got %0d", e.tu, tex_u); fail_cnt++;
          end
          if (longint'(tex_v) != e.tv) begin
            $error("tex_v: expected %0d, got %0d", e.tv, tex_v); fail_cnt++;
          end
          if (index_invalid !== e.bad) begin
            $error("index_invalid: expected %0d, got %0b", e.bad, index_invalid); fail_cnt++;
          end
        end
        g = rx_burst ? 0 : $urandom_range(0, 17);
      end
      if (rx_hold > 0) begin
        rx_hold--;
        pop <= 1'b0;
        rx_gap <= g;
      end else if (g > 0) begin
        rx_gap <= g - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        rx_gap <= 0;
      end
    end
  end

  // Watchdog: cycles without any transfer
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (psel && penable)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("** primitive_vertex_generator_core: FAILED **");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_SHAPE_KIND:    cfg_shape = val[1:0];
      REG_SEGMENT_COUNT: cfg_seg = val[10:0];
      REG_RING_COUNT:    cfg_rings = val[10:0];
      default:           cfg_half = val[HH_W-1:0];
    endcase
  endtask

  // Wait until all requests are sent and every vertex has come back
  task automatic wait_drained();
    while (req_q.size() > 0 || push || vertex_q.size() > 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_config(logic [1:0] shape, int seg, int rings, int half);
    wait_drained();
    reg_write(REG_SHAPE_KIND, 32'(shape));
    reg_write(REG_SEGMENT_COUNT, seg);
    reg_write(REG_RING_COUNT, rings);
    reg_write(REG_HALF_HEIGHT, half);
  endtask

  task automatic add_req(int ring, int col, int part);
    req_q.insert(req_q.size(), '{IDX_W'(ring), IDX_W'(col), PART_W'(part)});
  endtask

  // Random requests, mostly in range for the current shape, some raw noise
  task automatic add_random(int n);
    int ring, col, part;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        ring = $urandom_range(0, 2047);
        col = $urandom_range(0, 2047);
        part = $urandom_range(0, 7);
      end else begin
        col = $urandom_range(0, cfg_seg);
        part = $urandom_range(0, 4);
        if (cfg_shape == SHAPE_CYLINDER)
          ring = part == PART_SIDE ? $urandom_range(0, 1) : $urandom_range(0, 2047);
        else
          ring = $urandom_range(0, cfg_rings);
      end
      add_req(ring, col, part);
    end
  endtask

  initial begin
    int shape, seg, rings, half;
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    ring_index = '0;
    column_index = '0;
    cylinder_part = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    fail_cnt = 0;
    rx_hold = 0;
    tx_burst = 0;
    rx_burst = 0;
    idle_cycles = 0;
    cfg_shape = SHAPE_SPHERE;
    cfg_seg = 16;
    cfg_rings = 8;
    cfg_half = 256;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // defaults: poles, seam column, out-of-range ring and column, all-ones fields
    add_req(0, 0, 0);
    add_req(8, 5, 7);
    add_req(4, 16, 0);
    add_req(3, 17, 0);
    add_req(9, 2, 0);
    add_req(2047, 2047, 7);
    add_random(30);

    // capsule at the smallest counts and the largest half height
    set_config(SHAPE_CAPSULE, 3, 2, 32767);
    add_req(0, 0, 0);
    add_req(1, 3, 0);
    add_req(2, 1, 0);
    add_req(3, 0, 0);
    add_random(40);

    // cylinder: every part, bad parts, side ring and seam limits
    set_config(SHAPE_CYLINDER, 1024, 1, 0);
    for (int p = 0; p < 8; p++) add_req(1, 1024, p);
    add_req(2, 5, PART_SIDE);
    add_req(0, 1025, PART_SIDE);
    add_req(0, 1025, PART_TOP_RIM);
    add_req(0, 1025, PART_TOP_CENTRE);
    add_req(2047, 0, PART_BOT_CENTRE);
    add_random(40);

    // largest sphere, with a long receiver stall while requests keep coming
    set_config(SHAPE_SPHERE, 1024, 1024, 100);
    add_req(1024, 1024, 0);
    add_req(512, 256, 0);
    tx_burst = 1;
    @(negedge clk);
    rx_hold = 500;
    add_random(150);
    wait_drained();
    tx_burst = 0;

    // shape code 3 and out-of-range counts
    set_config(2'd3, 16, 8, 256);
    add_random(20);
    set_config(SHAPE_SPHERE, 2, 8, 256);
    add_random(15);
    set_config(SHAPE_CAPSULE, 1025, 1, 256);
    add_random(15);
    set_config(SHAPE_SPHERE, 16, 1025, 256);
    add_random(15);

    // random settings, each phase with its own idling style
    for (int ph = 0; ph < 12; ph++) begin
      shape = $urandom_range(0, 9) == 0 ? 3 : $urandom_range(0, 2);
      seg = $urandom_range(0, 3) == 0 ? $urandom_range(3, 1024) : $urandom_range(3, 40);
      rings = $urandom_range(0, 3) == 0 ? $urandom_range(2, 1024) : $urandom_range(2, 40);
      half = $urandom_range(0, 32767);
      if ($urandom_range(0, 7) == 0) begin
        seg = $urandom_range(0, 2047);
        rings = $urandom_range(0, 2047);
      end
      set_config(2'(shape), seg, rings, half);
      tx_burst = $urandom_range(0, 2) == 0;
      rx_burst = $urandom_range(0, 2) == 0;
      add_random(110);
    end

    wait_drained();
    if (fail_cnt == 0 && vertex_q.size() == 0) begin
      $display("** primitive_vertex_generator_core: PASSED **");
    end else begin
      $display("** primitive_vertex_generator_core: FAILED **");
    end
    $finish;
  end

endmodule
